### rtl/core/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/id3tx_pkg.sv
// Types, constants and codes of the tagged-text to UTF-8 transcoder.
package id3tx_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0]  LEAD2_BITS     = 8'hC0;
   localparam logic [7:0]  LEAD3_BITS     = 8'hE0;
   localparam logic [7:0]  CONT_BITS      = 8'h80;
   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [7:0]  BOM_FF         = 8'hFF;
   localparam logic [7:0]  BOM_FE         = 8'hFE;

   typedef enum logic [2:0] {
      MODE_LATIN1    = 3'd0,
      MODE_UTF16_BOM = 3'd1,
      MODE_UTF16_BE  = 3'd2,
      MODE_UTF8      = 3'd3,
      MODE_IDLE      = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0] text_encoding;
      logic       end_of_string;
      logic       start_of_string;
      logic       has_byte;
      logic [7:0] byte_in;
   } item_type;

   typedef struct packed {
      logic       end_mark;
      logic [7:0] utf8_byte;
   } entry_type;

   typedef struct packed {
      entry_type [MAX_RESULTS-1:0] ent;
      logic [CNT_W-1:0]            cnt;
   } result_type;

   typedef struct packed {
      logic             can_load;
      logic [CNT_W-1:0] cnt;
   } serial_status_type;

endpackage

### rtl/core/id3tx_decode.sv
// String state and per-item transcoding into up to four result bytes.
module id3tx_decode
   import id3tx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  item_type   item,
   output result_type result
);

   mode_type   mode_ff, mode_in;
   logic       stopped_ff, stopped_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       le_ff, le_in;
   logic       first_ff, first_in;

   // state as seen after the start of a string is handled
   mode_type   mode_e;
   logic       stopped_e, held_valid_e, le_e, first_e;
   logic [7:0] held_byte_e;

   logic        do_unit;
   logic [15:0] wc;
   logic [7:0]  b;
   entry_type [MAX_RESULTS-1:0] ent;
   logic [1:0]  dn;

   always_comb begin
      b = item.byte_in;
      if (item.start_of_string) begin
         mode_e       = (item.text_encoding <= 8'd3) ? mode_type'(item.text_encoding[2:0])
                                                     : MODE_IDLE;
         stopped_e    = 1'b0;
         held_byte_e  = 8'h00;
         held_valid_e = 1'b0;
         le_e         = 1'b0;
         first_e      = 1'b1;
      end else begin
         mode_e       = mode_ff;
         stopped_e    = stopped_ff;
         held_byte_e  = held_byte_ff;
         held_valid_e = held_valid_ff;
         le_e         = le_ff;
         first_e      = first_ff;
      end

      mode_in       = mode_e;
      stopped_in    = stopped_e;
      held_byte_in  = held_byte_e;
      held_valid_in = held_valid_e;
      le_in         = le_e;
      first_in      = first_e;
      do_unit       = 1'b0;
      wc            = 16'h0000;
      ent           = '0;
      dn            = 2'd0;

      if (item.has_byte && !stopped_e) begin
         case (mode_e)
            MODE_LATIN1, MODE_UTF8: begin
               if (b == 8'h00) begin
                  stopped_in = 1'b1;
               end else if (mode_e == MODE_UTF8) begin
                  ent[0].utf8_byte = b;
                  dn               = 2'd1;
               end else begin
                  do_unit = 1'b1;
                  wc      = {8'h00, b};
               end
            end
            MODE_UTF16_BOM, MODE_UTF16_BE: begin
               if (!held_valid_e) begin
                  held_byte_in  = b;
                  held_valid_in = 1'b1;
               end else begin
                  held_valid_in = 1'b0;
                  first_in      = 1'b0;
                  if (first_e && mode_e == MODE_UTF16_BOM &&
                      ((held_byte_e == BOM_FF && b == BOM_FE) ||
                       (held_byte_e == BOM_FE && b == BOM_FF))) begin
                     le_in = (held_byte_e == BOM_FF);
                  end else begin
                     wc = le_e ? {b, held_byte_e} : {held_byte_e, b};
                     if (wc == 16'h0000) begin
                        stopped_in = 1'b1;
                     end else begin
                        do_unit = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (do_unit) begin
         if (wc < ONE_BYTE_LIMIT) begin
            ent[0].utf8_byte = wc[7:0];
            dn               = 2'd1;
         end else if (wc < TWO_BYTE_LIMIT) begin
            ent[0].utf8_byte = LEAD2_BITS | {3'b000, wc[10:6]};
            ent[1].utf8_byte = CONT_BITS | {2'b00, wc[5:0]};
            dn               = 2'd2;
         end else begin
            ent[0].utf8_byte = LEAD3_BITS | {4'h0, wc[15:12]};
            ent[1].utf8_byte = CONT_BITS | {2'b00, wc[11:6]};
            ent[2].utf8_byte = CONT_BITS | {2'b00, wc[5:0]};
            dn               = 2'd3;
         end
      end

      result.cnt = CNT_W'(dn);
      if (item.end_of_string) begin
         // terminator after the data bytes, then back to the reset state
         ent[dn].utf8_byte = 8'h00;
         ent[dn].end_mark  = 1'b1;
         result.cnt        = CNT_W'(dn) + CNT_W'(1);
         mode_in           = MODE_IDLE;
         stopped_in        = 1'b0;
         held_byte_in      = 8'h00;
         held_valid_in     = 1'b0;
         le_in             = 1'b0;
         first_in          = 1'b1;
      end
      result.ent = ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         stopped_ff    <= 1'b0;
         held_byte_ff  <= 8'h00;
         held_valid_ff <= 1'b0;
         le_ff         <= 1'b0;
         first_ff      <= 1'b1;
      end else if (load) begin
         mode_ff       <= mode_in;
         stopped_ff    <= stopped_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         le_ff         <= le_in;
         first_ff      <= first_in;
      end
   end

endmodule

### rtl/core/id3tx_serial.sv
// Result buffer that hands out the bytes of one item, one per cycle while rsp_tready is high.
module id3tx_serial
   import id3tx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  result_type        result,
   output serial_status_type status,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   entry_type [MAX_RESULTS-1:0] buf_ff;
   logic [CNT_W-1:0]            cnt_ff;

   assign rsp_tvalid      = (cnt_ff != '0);
   assign rsp_tdata       = buf_ff[0].utf8_byte;
   assign rsp_tlast       = buf_ff[0].end_mark;
   assign status.cnt      = cnt_ff;
   assign status.can_load = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= result.cnt;
      end else if (rsp_tvalid && rsp_tready) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= result.ent;
      end else if (rsp_tvalid && rsp_tready) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
         buf_ff[MAX_RESULTS-1] <= '0;
      end
   end

endmodule

### rtl/core/id3_text_to_utf8_transcoder.sv
// Top level of the tagged-text to UTF-8 transcoder.
//
//  channel | dir | tdata              | tuser / tlast
//  req     | in  | byte_in[7:0]       | has_byte, start_of_string, text_encoding[7:0]; end_of_string
//  rsp     | out | utf8_byte[7:0]     | -; end_mark
//
// An item is held in the input register, then its 0 to 4 result bytes
// (up to three data bytes and a terminator) leave the result buffer one per cycle
// while rsp_tready is high; the result channel sets the rate.
// While an item is held and one byte remains in the buffer, req_tready follows rsp_tready.
// Reset is synchronous; it empties both registers and returns to the idle mode.
module id3_text_to_utf8_transcoder
   import id3tx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // byte_in[7:0]
   input  logic [9:0] req_tuser,   // has_byte[0], start_of_string[1], text_encoding[9:2]
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // utf8_byte[7:0]
   output logic       rsp_tlast    // end_mark
);

`include "assert_macros.svh"

   item_type          item_ff;
   logic              in_valid_ff;
   logic              move;
   result_type        result;
   serial_status_type status;

   assign move       = in_valid_ff && status.can_load;
   assign req_tready = !in_valid_ff || move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.byte_in         <= req_tdata;
         item_ff.has_byte        <= req_tuser[0];
         item_ff.start_of_string <= req_tuser[1];
         item_ff.text_encoding   <= req_tuser[9:2];
         item_ff.end_of_string   <= req_tlast;
      end
   end

   id3tx_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .load   (move),
      .item   (item_ff),
      .result (result)
   );

   id3tx_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (move),
      .result     (result),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `ASSERT_CLK(a_term_is_zero, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'h00, "terminator byte not zero")
   `ASSERT_CLK(a_cnt_bound, clock, reset, status.cnt <= CNT_W'(MAX_RESULTS), "buffer count out of range")
   `ASSERT_CLK(a_empty_loads, clock, reset, in_valid_ff && status.cnt == '0 |-> move, "held item not moved into empty buffer")

endmodule
